[sv/sine_square_oscillator_macros.svh]
// assertion macros for the sine and square oscillator checker
`ifndef SINE_SQUARE_OSCILLATOR_MACROS_SVH
`define SINE_SQUARE_OSCILLATOR_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define SSO_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the cycle after the trigger
`define SSO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sso_pkg.sv]
// shared constants, types and tables of the sine and square oscillator
package sso_pkg;

  localparam int PHASE_BITS  = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int SINE_STEPS  = 16;

  localparam int TURN_W      = 32;
  localparam int AMP_W       = 15;
  localparam int WAVE_W      = 2;
  localparam int COUNT_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CORDIC_W    = 34;
  localparam int K_W         = 30;
  localparam int X0_SHIFT    = 14;
  localparam int Y_FRAC_BITS = 16;
  localparam int STEP_W      = (SINE_STEPS > 1) ? $clog2(SINE_STEPS) : 1;
  localparam int ATAN_IDX_W  = 5;

  // cordic gain compensation in q30
  localparam logic [K_W-1:0] K_Q30 = K_W'(652032874);

  localparam logic [TURN_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [TURN_W-1:0] HALF_TURN    = 32'h8000_0000;

  typedef enum logic [WAVE_W-1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_COSINE = 2'd1,
    WAVE_SQUARE = 2'd2
  } wave_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAVEFORM  = 3'd0,
    REG_AMPLITUDE = 3'd1,
    REG_PHASE     = 3'd2,
    REG_PERIOD    = 3'd3,
    REG_HIGH      = 3'd4
  } cfg_reg_e;

  // controller to datapath commands
  typedef struct packed {
    logic              capture;
    logic              setup;
    logic              iterate;
    logic [STEP_W-1:0] step;
    logic              load_out;
  } cmd_t;

  // arctangent of 2^-i in 32-bit turn units
  function automatic logic [TURN_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [TURN_W-1:0] r;
    case (idx)
      5'd0:    r = 32'h2000_0000;
      5'd1:    r = 32'h12E4_051E;
      5'd2:    r = 32'h09FB_385B;
      5'd3:    r = 32'h0511_11D4;
      5'd4:    r = 32'h028B_0D43;
      5'd5:    r = 32'h0145_D7E1;
      5'd6:    r = 32'h00A2_F61E;
      5'd7:    r = 32'h0051_7C55;
      5'd8:    r = 32'h0028_BE53;
      5'd9:    r = 32'h0014_5F2F;
      5'd10:   r = 32'h000A_2F98;
      5'd11:   r = 32'h0005_17CC;
      5'd12:   r = 32'h0002_8BE6;
      5'd13:   r = 32'h0001_45F3;
      5'd14:   r = 32'h0000_A2FA;
      5'd15:   r = 32'h0000_517D;
      5'd16:   r = 32'h0000_28BE;
      5'd17:   r = 32'h0000_145F;
      5'd18:   r = 32'h0000_0A30;
      5'd19:   r = 32'h0000_0518;
      5'd20:   r = 32'h0000_028C;
      5'd21:   r = 32'h0000_0146;
      5'd22:   r = 32'h0000_00A3;
      5'd23:   r = 32'h0000_0051;
      5'd24:   r = 32'h0000_0029;
      5'd25:   r = 32'h0000_0014;
      5'd26:   r = 32'h0000_000A;
      5'd27:   r = 32'h0000_0005;
      5'd28:   r = 32'h0000_0003;
      5'd29:   r = 32'h0000_0001;
      5'd30:   r = 32'h0000_0001;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

[sv/sso_ctrl.sv]
// sequencing state machine and output word valid of the oscillator
module sso_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sso_pkg::cmd_t cmd_o
);
  import sso_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_ITER  = 4'b0100,
    ST_FINAL = 4'b1000
  } state_e;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SINE_STEPS - 1);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              accept;
  logic              load;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign load        = (state_q == ST_FINAL) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  // next state and iteration count
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_d = ST_ITER;
        step_d  = '0;
      end
      ST_ITER: begin
        if (step_q == LAST_STEP) begin
          state_d = ST_FINAL;
          step_d  = '0;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_FINAL: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  // output word valid: set on load, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // datapath commands
  always_comb begin
    cmd_o.capture  = accept;
    cmd_o.setup    = (state_q == ST_SETUP);
    cmd_o.iterate  = (state_q == ST_ITER);
    cmd_o.step     = step_q;
    cmd_o.load_out = load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[sv/sso_datapath.sv]
// config registers, counters, cordic rotator and output register
module sso_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sso_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [sso_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                 in_restart_i,
  input  sso_pkg::cmd_t                        cmd_i,
  output logic signed [sso_pkg::SAMPLE_BITS-1:0] out_sample_o
);
  import sso_pkg::*;

  localparam int CW      = CORDIC_W;
  localparam int PROD_W  = AMP_W + K_W;
  localparam logic signed [CW-1:0] SAMPLE_LIM =
    $signed(CW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1));

  // configuration
  logic [WAVE_W-1:0]     wave_q;
  logic [AMP_W-1:0]      amp_q;
  logic [CFG_DATA_W-1:0] step_q;
  logic [COUNT_W-1:0]    period_q;
  logic [COUNT_W-1:0]    high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q   <= WAVE_W'(WAVE_SINE);
      amp_q    <= '0;
      step_q   <= '0;
      period_q <= COUNT_W'(1);
      high_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_WAVEFORM:  wave_q   <= cfg_wdata_i[WAVE_W-1:0];
        REG_AMPLITUDE: amp_q    <= cfg_wdata_i[AMP_W-1:0];
        REG_PHASE:     step_q   <= cfg_wdata_i;
        REG_PERIOD:    period_q <= cfg_wdata_i[COUNT_W-1:0];
        REG_HIGH:      high_q   <= cfg_wdata_i[COUNT_W-1:0];
        default:       ;
      endcase
    end
  end

  // restart flag of the word in flight
  logic restart_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      restart_q <= in_restart_i;
    end
  end

  // phase accumulator and square counter
  logic [PHASE_BITS-1:0] phase_q, phase_d, eff_phase, step_ext;
  logic [COUNT_W-1:0]    pos_q, pos_d, eff_pos, pos_fix, period;
  logic [COUNT_W:0]      pos_inc;
  logic [TURN_W-1:0]     turn, turn_sel, turn_fold;
  logic                  sq_on_q;

  assign eff_phase = restart_q ? '0 : phase_q;
  assign eff_pos   = restart_q ? '0 : pos_q;

  if (PHASE_BITS >= TURN_W) begin : g_wide_phase
    assign turn     = eff_phase[PHASE_BITS-1 -: TURN_W];
    assign step_ext = PHASE_BITS'(step_q);
  end else begin : g_narrow_phase
    assign turn     = {eff_phase, {(TURN_W - PHASE_BITS){1'b0}}};
    assign step_ext = step_q[PHASE_BITS-1:0];
  end

  assign phase_d = eff_phase + step_ext;

  always_comb begin
    period  = (period_q == '0) ? COUNT_W'(1) : period_q;
    pos_fix = (eff_pos >= period) ? '0 : eff_pos;
    pos_inc = {1'b0, pos_fix} + 1'b1;
    pos_d   = (pos_inc >= {1'b0, period}) ? '0 : pos_inc[COUNT_W-1:0];
  end

  // shift the cosine by a quarter turn, then fold the turn into the right half plane
  always_comb begin
    turn_sel  = (wave_q == WAVE_W'(WAVE_COSINE)) ? turn + QUARTER_TURN : turn;
    turn_fold = turn_sel;
    if (turn_sel[TURN_W-1] != turn_sel[TURN_W-2]) begin
      turn_fold = HALF_TURN - turn_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      pos_q   <= '0;
    end else if (cmd_i.setup) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
    end
  end

  // cordic rotator, one micro-rotation a cycle
  logic [PROD_W-1:0]      prod;
  logic signed [CW-1:0]   x_q, y_q, z_q;
  logic signed [CW-1:0]   dx, dy, ang;

  assign prod = PROD_W'(amp_q) * PROD_W'(K_Q30);
  assign dx   = y_q >>> cmd_i.step;
  assign dy   = x_q >>> cmd_i.step;
  assign ang  = $signed(CW'(atan_turn(ATAN_IDX_W'(cmd_i.step))));

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      x_q     <= $signed(CW'(prod >> X0_SHIFT));
      y_q     <= '0;
      z_q     <= $signed(CW'($signed(turn_fold)));
      sq_on_q <= (pos_fix < high_q);
    end else if (cmd_i.iterate) begin
      if (!z_q[CW-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - ang;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + ang;
      end
    end
  end

  // scale back, clamp and select the waveform
  logic                 y_neg;
  logic signed [CW-1:0] y_abs, y_sh, y_tr, y_clamp, amp_s, sel, res;

  always_comb begin
    amp_s   = $signed(CW'(amp_q));
    y_neg   = y_q[CW-1];
    y_abs   = y_neg ? -y_q : y_q;
    y_sh    = y_abs >>> Y_FRAC_BITS;
    y_tr    = y_neg ? -y_sh : y_sh;
    y_clamp = y_tr;
    if (y_tr > amp_s) begin
      y_clamp = amp_s;
    end else if (y_tr < -amp_s) begin
      y_clamp = -amp_s;
    end
    case (wave_e'(wave_q))
      WAVE_SINE:   sel = y_clamp;
      WAVE_COSINE: sel = y_clamp;
      WAVE_SQUARE: sel = sq_on_q ? amp_s : '0;
      default:     sel = '0;
    endcase
    res = sel;
    if (sel > SAMPLE_LIM) begin
      res = SAMPLE_LIM;
    end else if (sel < -SAMPLE_LIM) begin
      res = -SAMPLE_LIM;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_sample_o <= res[SAMPLE_BITS-1:0];
    end
  end

endmodule

[sv/sine_square_oscillator.sv]
// top level of the sine, cosine and square oscillator
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one sample tick per word,
//   with in_restart_i clearing the phase accumulator and square counter first.
//   Output channel (out_valid_o / out_ready_i) returns one signed sample per
//   tick, out_sample_o, in two's complement.
//   Configuration is a write-only port: cfg_we_i, cfg_index_i, cfg_wdata_i,
//   index 0 waveform, 1 amplitude, 2 phase step, 3 period, 4 high count.
// Timing:
//   A word is taken in the idle state, then passes the setup state, the cordic
//   loop, one micro-rotation per cycle in the shared rotator, and the final
//   state, in which the scaled sample is loaded into the output register.
//   No new word is taken until the last one has been loaded.
// Reset:
//   rst_ni clears the configuration, counters and control state (period 1, all others 0) at once.
// Stall:
//   A finished sample waits in the output register; the next word can be
//   taken and computed meanwhile, and finishes once the register frees.
module sine_square_oscillator (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [sso_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [sso_pkg::CFG_DATA_W-1:0]         cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   in_restart_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [sso_pkg::SAMPLE_BITS-1:0] out_sample_o
);
  import sso_pkg::*;

  cmd_t cmd;

  // sequencing
  sso_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  sso_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_restart_i (in_restart_i),
    .cmd_i        (cmd),
    .out_sample_o (out_sample_o)
  );

endmodule

[sv/sso_checker.sv]
// port-level checks of the oscillator, bound to the top level
`include "sine_square_oscillator_macros.svh"

module sso_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_ready_i,
  input logic                                   out_valid_i,
  input logic                                   out_ready_i,
  input logic signed [sso_pkg::SAMPLE_BITS-1:0] out_sample_i
);
  import sso_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  // a stalled word stays valid and unchanged
  `SSO_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "output word dropped while stalled")
  `SSO_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_sample_i), "output word changed while stalled")

  // one tick in flight at a time
  `SSO_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "input taken twice in a row")

  // samples saturate symmetrically, never the most negative code
  `SSO_ASSERT_SAME(a_no_min, clk_i, rst_ni, out_valid_i, out_sample_i != SAMPLE_MIN, "sample at most negative code")

endmodule

bind sine_square_oscillator sso_checker u_sso_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_i   (in_ready_o),
  .out_valid_i  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_sample_i (out_sample_o)
);

[test/sine_square_oscillator_chk.sv]
// checker for the oscillator: watches both channels and the register port, predicts, compares
`timescale 1ns / 1ps

module sine_square_oscillator_chk (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sso_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sso_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic                            in_restart_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [sso_pkg::SAMPLE_BITS-1:0] out_sample_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              checked_o
);
  import sso_pkg::*;

  localparam int MAX_REPORTS = 10;

  // arctangent of 2^-i, one full turn is 2^32
  localparam logic [TURN_W-1:0] ARCTAN_TURNS [0:31] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
    32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
    32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
    32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051, 32'h0000_0029,
    32'h0000_0014, 32'h0000_000A, 32'h0000_0005, 32'h0000_0003, 32'h0000_0001,
    32'h0000_0001, 32'h0000_0000
  };

  // shadow registers
  logic [WAVE_W-1:0]  wave_sel;
  logic [AMP_W-1:0]   amp_reg;
  logic [TURN_W-1:0]  step_reg;
  logic [COUNT_W-1:0] period_reg;
  logic [COUNT_W-1:0] high_reg;

  // shadow counters
  logic [TURN_W-1:0]  phase_acc;
  logic [COUNT_W-1:0] square_pos;

  logic [SAMPLE_BITS-1:0] sample_q [$];
  int                     mismatches;

  // amplitude times sine of a turn, by cordic rotation, truncated toward zero
  function automatic longint rotate_sine(input logic [TURN_W-1:0] turn,
                                         input logic [AMP_W-1:0]  amp);
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    longint      a;
    logic [TURN_W-1:0] t;
    int          i;
    x = (longint'(amp) * longint'(K_Q30)) >>> X0_SHIFT;
    y = 0;
    t = turn;
    // fold the second and third quadrant onto the first and fourth
    if (t[TURN_W-1:TURN_W-2] == 2'b01 || t[TURN_W-1:TURN_W-2] == 2'b10)
      t = HALF_TURN - t;
    z = longint'($signed(t));
    for (i = 0; i < SINE_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      a  = longint'(ARCTAN_TURNS[i % 32]);
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - a;
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + a;
      end
    end
    if (y >= 0) y = y >>> Y_FRAC_BITS;
    else        y = -((-y) >>> Y_FRAC_BITS);
    if (y > longint'(amp))  y = longint'(amp);
    if (y < -longint'(amp)) y = -longint'(amp);
    return y;
  endfunction

  // one sample tick: form the sample from the current counters, then advance them
  function automatic logic [SAMPLE_BITS-1:0] osc_tick(input logic restart);
    logic [COUNT_W-1:0] per;
    longint             s;
    longint             lim;
    per = (period_reg == '0) ? COUNT_W'(1) : period_reg;
    lim = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    if (restart) begin
      phase_acc  = '0;
      square_pos = '0;
    end
    // position left over from a longer period
    if (square_pos >= per) square_pos = '0;
    case (wave_sel)
      WAVE_SINE:   s = rotate_sine(phase_acc, amp_reg);
      WAVE_COSINE: s = rotate_sine(phase_acc + QUARTER_TURN, amp_reg);
      WAVE_SQUARE: s = (square_pos < high_reg) ? longint'(amp_reg) : 0;
      default:     s = 0;
    endcase
    if (s > lim)  s = lim;
    if (s < -lim) s = -lim;
    phase_acc = phase_acc + step_reg;
    if (32'(square_pos) + 1 >= 32'(per)) square_pos = '0;
    else                                 square_pos = square_pos + 1'b1;
    return s[SAMPLE_BITS-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [SAMPLE_BITS-1:0] want;
    if (!rst_ni) begin
      wave_sel     = WAVE_SINE;
      amp_reg      = '0;
      step_reg     = '0;
      period_reg   = COUNT_W'(1);
      high_reg     = '0;
      phase_acc    = '0;
      square_pos   = '0;
      sample_q.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_WAVEFORM:  wave_sel   = cfg_wdata_i[WAVE_W-1:0];
          REG_AMPLITUDE: amp_reg    = cfg_wdata_i[AMP_W-1:0];
          REG_PHASE:     step_reg   = cfg_wdata_i[TURN_W-1:0];
          REG_PERIOD:    period_reg = cfg_wdata_i[COUNT_W-1:0];
          REG_HIGH:      high_reg   = cfg_wdata_i[COUNT_W-1:0];
          default:       ;
        endcase
      end
      // returned sample against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (sample_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch %0d: sample %0d returned with nothing predicted",
                     mismatches, $signed(out_sample_i));
        end else begin
          want = sample_q.pop_front();
          if (out_sample_i !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch %0d: sample expected %0d got %0d",
                       mismatches, $signed(want), $signed(out_sample_i));
          end
        end
        checked_o <= checked_o + 1;
      end
      // accepted tick
      if (in_valid_i && in_ready_i)
        sample_q.push_back(osc_tick(in_restart_i));
      fail_count_o <= mismatches;
      pending_o    <= sample_q.size();
    end
  end

endmodule

[test/sine_square_oscillator_tb.sv]
// testbench top for the oscillator: clock, reset, tick and register stimulus, verdict
`timescale 1ns / 1ps

module sine_square_oscillator_tb;
  import sso_pkg::*;

  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS   = 1150;
  localparam int MAX_GAP        = 18;
  localparam int CYCLE_LIMIT    = 400000;
  localparam logic [WAVE_W-1:0] WAVE_SPARE = 2'd3;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic                   in_restart_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [SAMPLE_BITS-1:0] out_sample_o;

  int fail_count;
  int pending;
  int checked;

  int cycle_count = 0;
  int items_sent  = 0;
  int restarts    = 0;
  int settings    = 0;
  int rx_wait     = 0;
  bit tx_calm     = 1'b0;
  bit rx_calm     = 1'b0;

  int                    pick;
  int                    burst;
  int                    restart_pct;
  int                    n;
  logic [CFG_DATA_W-1:0] wdata;

  sine_square_oscillator u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_restart_i (in_restart_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_sample_o (out_sample_o)
  );

  sine_square_oscillator_chk u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_restart_i (in_restart_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_sample_i (out_sample_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #1 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // sample sink: random stall after every taken word, none in calm stretches
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      rx_wait = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (rx_wait > 0) begin
      out_ready_i <= 1'b0;
      rx_wait--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // one register write, the enable stays up for back to back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // one tick word after a random gap, returns once it is taken
  task automatic send_tick(input logic restart);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_restart_i <= restart;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (restart) restarts++;
  endtask

  // drop valid and wait until every predicted sample has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    settings++;
  endtask

  // sometimes set bits above the register width, they must be ignored
  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                      input int w);
    if (w < CFG_DATA_W && $urandom_range(0, 3) == 0)
      return v | ($urandom << w);
    return v;
  endfunction

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= REG_WAVEFORM;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    in_restart_i <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: sine at zero amplitude
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    settle();

    // full scale sine at the quarter points
    write_reg(REG_AMPLITUDE, CFG_DATA_W'(32767));
    write_reg(REG_PHASE, QUARTER_TURN);
    cfg_we_i <= 1'b0;
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    settle();

    // cosine in eighth turns
    write_reg(REG_WAVEFORM, CFG_DATA_W'(WAVE_COSINE));
    write_reg(REG_PHASE, QUARTER_TURN >> 1);
    cfg_we_i <= 1'b0;
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    settle();

    // square with a zero period
    write_reg(REG_WAVEFORM, CFG_DATA_W'(WAVE_SQUARE));
    write_reg(REG_PERIOD, '0);
    write_reg(REG_HIGH, CFG_DATA_W'(1));
    cfg_we_i <= 1'b0;
    repeat (3) send_tick(1'b0);
    settle();

    // period of five, three high, stop at the last position
    write_reg(REG_PERIOD, CFG_DATA_W'(5));
    write_reg(REG_HIGH, CFG_DATA_W'(3));
    cfg_we_i <= 1'b0;
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    settle();

    // period lowered below the current position
    write_reg(REG_PERIOD, CFG_DATA_W'(2));
    cfg_we_i <= 1'b0;
    repeat (2) send_tick(1'b0);
    settle();

    // unused waveform code
    write_reg(REG_WAVEFORM, CFG_DATA_W'(WAVE_SPARE));
    cfg_we_i <= 1'b0;
    repeat (2) send_tick(1'b0);
    settle();

    // smallest amplitude, largest step, a write to an unused index
    write_reg(REG_WAVEFORM, CFG_DATA_W'(WAVE_SINE));
    write_reg(REG_AMPLITUDE, CFG_DATA_W'(1));
    write_reg(REG_PHASE, '1);
    write_reg(CFG_IDX_W'(REG_HIGH + 1), '1);
    cfg_we_i <= 1'b0;
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);
    settle();

    // random settings, each followed by a burst of ticks
    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) begin
        pick  = $urandom_range(0, 9);
        wdata = (pick < 3) ? CFG_DATA_W'(WAVE_SINE) :
                (pick < 6) ? CFG_DATA_W'(WAVE_COSINE) :
                (pick < 9) ? CFG_DATA_W'(WAVE_SQUARE) : CFG_DATA_W'(WAVE_SPARE);
        write_reg(REG_WAVEFORM, with_junk(wdata, WAVE_W));
      end
      if ($urandom_range(0, 1)) begin
        pick  = $urandom_range(0, 5);
        wdata = (pick == 0) ? '0 : (pick == 1) ? CFG_DATA_W'(1) :
                (pick == 2) ? CFG_DATA_W'(32767) : CFG_DATA_W'($urandom_range(0, 32767));
        write_reg(REG_AMPLITUDE, with_junk(wdata, AMP_W));
      end
      if ($urandom_range(0, 1)) begin
        pick  = $urandom_range(0, 7);
        wdata = (pick == 0) ? '0 : (pick == 1) ? '1 : (pick == 2) ? HALF_TURN :
                (pick < 5) ? CFG_DATA_W'($urandom_range(0, 65535)) : $urandom;
        write_reg(REG_PHASE, wdata);
      end
      if ($urandom_range(0, 1)) begin
        pick  = $urandom_range(0, 9);
        wdata = (pick == 0) ? '0 : (pick == 1) ? CFG_DATA_W'(1) :
                (pick == 2) ? CFG_DATA_W'(65535) :
                (pick == 3) ? CFG_DATA_W'($urandom_range(0, 65535)) :
                CFG_DATA_W'($urandom_range(2, 40));
        write_reg(REG_PERIOD, with_junk(wdata, COUNT_W));
      end
      if ($urandom_range(0, 1)) begin
        pick  = $urandom_range(0, 7);
        wdata = (pick == 0) ? '0 : (pick == 1) ? CFG_DATA_W'(65535) :
                (pick == 2) ? CFG_DATA_W'($urandom_range(0, 65535)) :
                CFG_DATA_W'($urandom_range(0, 42));
        write_reg(REG_HIGH, with_junk(wdata, COUNT_W));
      end
      if ($urandom_range(0, 9) == 0)
        write_reg(CFG_IDX_W'(REG_HIGH + 1 + $urandom_range(0, 2)), $urandom);
      cfg_we_i <= 1'b0;

      pick        = $urandom_range(0, 3);
      restart_pct = (pick == 0) ? 0 : (pick == 1) ? 40 : 4;
      burst       = $urandom_range(8, 60);
      for (n = 0; n < burst; n++)
        send_tick($urandom_range(0, 99) < restart_pct);
      settle();
    end

    // nothing more may come out
    repeat (2 * SINE_STEPS + 8) @(posedge clk_i);

    $display("summary: %0d ticks over %0d register settings, %0d with restart",
             items_sent, settings, restarts);
    $display("summary: %0d samples compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/sso_pkg.sv
sv/sso_ctrl.sv
sv/sso_datapath.sv
sv/sine_square_oscillator.sv
sv/sso_checker.sv
test/sine_square_oscillator_chk.sv
test/sine_square_oscillator_tb.sv
